### rtl/priority_table_increase_key_top_macros.svh
// Assertion macros used by the priority table datapath.
`ifndef PRIORITY_TABLE_INCREASE_KEY_TOP_MACROS_SVH
`define PRIORITY_TABLE_INCREASE_KEY_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, masked while reset is asserted
`define PTIK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property, also sampled during reset
`define PTIK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PTIK_ASSERT(lbl, prop, msg)
`define PTIK_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/ptik_pkg.sv
package ptik_pkg;

  // Default sizes
  localparam int unsigned DefCapacity     = 256;
  localparam int unsigned DefPayloadBits  = 32;
  localparam int unsigned DefPriorityBits = 16;

  // Operation codes
  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_PROMOTE = 3'd1,
    FUNC_PEEK    = 3'd2,
    FUNC_POP     = 3'd3,
    FUNC_TEST    = 3'd4,
    FUNC_READ    = 3'd5
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_SCAN,
    S_DRAIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_clr;
    logic scan_issue;
    logic scan_commit;
  } ptik_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
    logic need_scan;
    logic scan_end;
  } ptik_stat_t;

endpackage

### rtl/ptik_chan_if.sv
// Operation channel
interface ptik_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  item_id;
  logic [31:0] payload;

  modport source (output valid, func, item_id, payload, input ready);
  modport sink (input valid, func, item_id, payload, output ready);
endinterface

// Result channel
interface ptik_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_id;
  logic [31:0] out_payload;
  logic [15:0] out_priority;
  logic        is_present;

  modport source (output valid, status, out_id, out_payload, out_priority, is_present,
                  input ready);
  modport sink (input valid, status, out_id, out_payload, out_priority, is_present,
                output ready);
endinterface

### rtl/priority_table_increase_key_top.sv
// Channel  Dir  Payload                                              Handshake
// in_i     in   func, item_id, payload                               valid/ready
// out_o    out  status, out_id, out_payload, out_priority, is_present valid/ready
//
// Every operation passes through accept, memory read, and execute into the output register.
// A pop from a non-empty table then scans the table, reading one stored priority a cycle
// through the single read port, and commits the new maximum in the drain state.
// Reset is asynchronous, active low, and leaves the table empty; no clearing pass.
// A result waiting on out_o holds the execute step, not the accept of the next item.
module priority_table_increase_key_top
  import ptik_pkg::*;
#(
  parameter int unsigned CAPACITY      = DefCapacity,
  parameter int unsigned PAYLOAD_BITS  = DefPayloadBits,
  parameter int unsigned PRIORITY_BITS = DefPriorityBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptik_in_if.sink       in_i,
  ptik_out_if.source    out_o
);

  ptik_cmd_t  cmd;
  ptik_stat_t stat;

  ptik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptik_dp #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (in_i.func),
    .item_id_i      (in_i.item_id),
    .payload_i      (in_i.payload),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .out_id_o       (out_o.out_id),
    .out_payload_o  (out_o.out_payload),
    .out_priority_o (out_o.out_priority),
    .is_present_o   (out_o.is_present)
  );

endmodule

### rtl/ptik_ctrl.sv
module ptik_ctrl
  import ptik_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ptik_stat_t stat_i,
  output ptik_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!stat_i.out_busy) begin
          cmd_o.exec = 1'b1;
          if (stat_i.need_scan) begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        cmd_o.scan_commit = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/ptik_dp.sv
`include "priority_table_increase_key_top_macros.svh"

module ptik_dp
  import ptik_pkg::*;
#(
  parameter int unsigned CAPACITY      = DefCapacity,
  parameter int unsigned PAYLOAD_BITS  = DefPayloadBits,
  parameter int unsigned PRIORITY_BITS = DefPriorityBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ptik_cmd_t   cmd_i,
  output ptik_stat_t  stat_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  item_id_i,
  input  logic [31:0] payload_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  out_id_o,
  output logic [31:0] out_payload_o,
  output logic [15:0] out_priority_o,
  output logic        is_present_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned PW = PAYLOAD_BITS;
  localparam int unsigned RW = PRIORITY_BITS;

  // Operation registers
  func_e       func_q;
  logic [7:0]  id_q;
  logic [PW-1:0] pay_q;
  logic [PW+31:0] pay_in_ext;

  assign pay_in_ext = {PW'(0), payload_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      id_q   <= item_id_i;
      pay_q  <= pay_in_ext[PW-1:0];
    end
  end

  // Table state
  logic [CAPACITY-1:0] present_q;
  logic [CW-1:0]       next_id_q;
  logic                max_valid_q;
  logic [IW-1:0]       max_id_q;
  logic [RW-1:0]       max_prio_q;

  logic [PW-1:0] pay_mem [CAPACITY];
  logic [RW-1:0] prio_mem [CAPACITY];
  logic [PW-1:0] pay_rd_q;
  logic [RW-1:0] prio_rd_q;

  // Scan state
  logic [CW-1:0] cnt_q;
  logic          sv_q, spres_q;
  logic [IW-1:0] sidx_q;
  logic          found_q;
  logic [IW-1:0] best_id_q;
  logic [RW-1:0] best_p_q;

  // Id decode
  logic [15:0]   id_ext;
  logic          in_range, valid_id, full, is_max_op;
  logic [IW-1:0] id_idx, next_idx, rd_addr;
  logic [RW-1:0] new_prio;

  assign id_ext    = 16'(id_q);
  assign in_range  = id_ext < 16'(CAPACITY);
  assign id_idx    = IW'(id_ext);
  assign valid_id  = in_range && present_q[id_idx];
  assign full      = next_id_q >= CW'(CAPACITY);
  assign next_idx  = IW'(next_id_q);
  assign is_max_op = (func_q == FUNC_PEEK) || (func_q == FUNC_POP);
  assign new_prio  = (prio_rd_q == '1) ? prio_rd_q : prio_rd_q + 1'b1;

  always_comb begin
    if (cmd_i.scan_issue) begin
      rd_addr = IW'(cnt_q);
    end else if (is_max_op) begin
      rd_addr = max_id_q;
    end else begin
      rd_addr = id_idx;
    end
  end

  // Memories: one write, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && func_q == FUNC_ADD && !full) begin
      pay_mem[next_idx]  <= pay_q;
      prio_mem[next_idx] <= '0;
    end else if (cmd_i.exec && func_q == FUNC_PROMOTE && valid_id) begin
      prio_mem[id_idx] <= new_prio;
    end
    pay_rd_q  <= pay_mem[rd_addr];
    prio_rd_q <= prio_mem[rd_addr];
  end

  // Scan compare, later id wins ties
  logic          take;
  logic          found_d;
  logic [IW-1:0] best_id_d;
  logic [RW-1:0] best_p_d;

  assign take      = sv_q && spres_q && (!found_q || prio_rd_q >= best_p_q);
  assign found_d   = found_q || take;
  assign best_id_d = take ? sidx_q : best_id_q;
  assign best_p_d  = take ? prio_rd_q : best_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sv_q      <= 1'b0;
      spres_q   <= 1'b0;
      sidx_q    <= '0;
      found_q   <= 1'b0;
      best_id_q <= '0;
      best_p_q  <= '0;
    end else if (cmd_i.scan_clr) begin
      cnt_q   <= '0;
      sv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      sv_q      <= cmd_i.scan_issue;
      found_q   <= found_d;
      best_id_q <= best_id_d;
      best_p_q  <= best_p_d;
      if (cmd_i.scan_issue) begin
        spres_q <= present_q[IW'(cnt_q)];
        sidx_q  <= IW'(cnt_q);
        cnt_q   <= cnt_q + 1'b1;
      end
    end
  end

  // Table state and cached maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      next_id_q   <= '0;
      max_valid_q <= 1'b0;
      max_id_q    <= '0;
      max_prio_q  <= '0;
    end else if (cmd_i.scan_commit) begin
      max_valid_q <= found_d;
      max_id_q    <= best_id_d;
      max_prio_q  <= best_p_d;
    end else if (cmd_i.exec) begin
      case (func_q)
        FUNC_ADD: begin
          if (!full) begin
            present_q[next_idx] <= 1'b1;
            next_id_q           <= next_id_q + 1'b1;
            // new id is the largest, so it wins any tie at zero
            if (!max_valid_q || max_prio_q == '0) begin
              max_valid_q <= 1'b1;
              max_id_q    <= next_idx;
              max_prio_q  <= '0;
            end
          end
        end
        FUNC_PROMOTE: begin
          if (valid_id) begin
            if (id_idx == max_id_q || new_prio > max_prio_q ||
                (new_prio == max_prio_q && id_idx > max_id_q)) begin
              max_id_q   <= id_idx;
              max_prio_q <= new_prio;
            end
          end
        end
        FUNC_POP: begin
          if (max_valid_q) begin
            present_q[max_id_q] <= 1'b0;
            max_valid_q         <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields
  logic [PW+31:0] pay_out_ext;
  logic [RW+15:0] prio_out_ext;
  status_e        res_status;
  logic [7:0]     res_id;
  logic [31:0]    res_pay;
  logic [15:0]    res_prio;
  logic           res_pres;

  assign pay_out_ext  = {32'd0, pay_rd_q};
  assign prio_out_ext = {16'd0, prio_rd_q};

  always_comb begin
    res_status = STAT_OK;
    res_id     = '0;
    res_pay    = '0;
    res_prio   = '0;
    res_pres   = 1'b0;
    case (func_q)
      FUNC_ADD: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          res_id = 8'(next_idx);
        end
      end
      FUNC_PROMOTE: begin
        if (!valid_id) begin
          res_status = STAT_ABSENT;
        end
      end
      FUNC_PEEK, FUNC_POP: begin
        if (!max_valid_q) begin
          res_status = STAT_EMPTY;
        end else begin
          res_id   = 8'(max_id_q);
          res_pay  = pay_out_ext[31:0];
          res_prio = prio_out_ext[15:0];
        end
      end
      FUNC_TEST: begin
        res_pres = valid_id;
      end
      FUNC_READ: begin
        if (!valid_id) begin
          res_status = STAT_ABSENT;
        end else begin
          res_pay  = pay_out_ext[31:0];
          res_prio = prio_out_ext[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o       <= res_status;
      out_id_o       <= res_id;
      out_payload_o  <= res_pay;
      out_priority_o <= res_prio;
      is_present_o   <= res_pres;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign stat_o.need_scan = (func_q == FUNC_POP) && max_valid_q;
  assign stat_o.scan_end  = cnt_q == CW'(CAPACITY);

  // Checks
  `PTIK_ASSERT(a_max_present, max_valid_q |-> present_q[max_id_q], "cached maximum not present")
  `PTIK_ASSERT(a_next_bound, next_id_q <= CW'(CAPACITY), "next id beyond capacity")
  `PTIK_ASSERT(a_no_overwrite, cmd_i.exec |-> !stat_o.out_busy, "result overwritten")
  `PTIK_ASSERT(a_pop_clears, cmd_i.exec && func_q == FUNC_POP && max_valid_q |=> !present_q[$past(max_id_q)], "popped entry still present")

endmodule
